// ===== hdl/frdr_pkg.sv =====
// Package: item types, controller commands and status, states and constants.
`timescale 1ns / 1ps
package frdr_pkg;

    localparam int PTS_W = 48;
    localparam int TAG_W = 16;
    localparam int CNT_W = 32;
    localparam int CFG_W = 32;
    localparam int MAX_REPEATS = 63;
    localparam int REP_W = $clog2(MAX_REPEATS + 1);

    localparam logic [CFG_W-1:0] PERIOD_RESET = 32'd3000;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 32'd45000;

    // register indexes of the write port
    typedef enum logic [0:0] {
        CFG_FRAME_PERIOD = 1'b0,
        CFG_JUMP_LIMIT   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [PTS_W-1:0] in_pts;
        logic [TAG_W-1:0]        in_tag;
        logic                    in_valid;
    } in_item_t;

    typedef struct packed {
        logic signed [PTS_W-1:0] out_pts;
        logic [TAG_W-1:0]        out_tag;
        logic                    repeated;
        logic                    run_end;
        logic [CNT_W-1:0]        dup_count;
        logic [CNT_W-1:0]        drop_count;
        logic [CNT_W-1:0]        frames_in;
        logic [CNT_W-1:0]        frames_out;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1,
        ST_REP  = 2'd2,
        ST_PASS = 2'd3
    } state_t;

    typedef struct packed {
        logic ready;      // take an item this cycle
        logic load;       // capture the input payload
        logic eval;       // gap check, set up the repeat loop
        logic rep_emit;   // emit one repeat of the held frame
        logic early;      // store the frame as held and unused
        logic pass_emit;  // emit the current frame
    } ctl_cmd_t;

    typedef struct packed {
        logic item_valid;   // in_valid bit of the offered item
        logic pass_direct;  // first frame, aligned, or discontinuity
        logic rep_more;     // another repeat slot is due
        logic early;        // frame lies before the next slot
        logic out_free;     // output register can take a result
    } ctl_status_t;

endpackage

// ===== hdl/frdr_in_if.sv =====
// Input channel: frame descriptor items.
`timescale 1ns / 1ps
interface frdr_in_if;
    import frdr_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/frdr_out_if.sv =====
// Output channel: emitted frame items.
`timescale 1ns / 1ps
interface frdr_out_if;
    import frdr_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/frdr_ctrl.sv =====
// Controller: sequences the gap check, the repeat loop and the pass/hold step.
`timescale 1ns / 1ps
module frdr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  frdr_pkg::ctl_status_t status,
    output frdr_pkg::ctl_cmd_t    cmd
);
    import frdr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.item_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = status.pass_direct ? ST_PASS : ST_REP;
            end
            ST_REP:
            begin
                if (!status.rep_more)
                begin
                    state_next = status.early ? ST_IDLE : ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                cmd.load  = in_valid;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_REP:
            begin
                cmd.rep_emit = status.rep_more && status.out_free;
                cmd.early    = !status.rep_more && status.early;
            end
            ST_PASS:
            begin
                cmd.pass_emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/frdr_datapath.sv =====
// Datapath: timestamp state, counters, config registers and output register.
`timescale 1ns / 1ps
module frdr_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_idx,
    input  logic [frdr_pkg::CFG_W-1:0] cfg_data,
    input  frdr_pkg::in_item_t        in_data,
    input  logic                      out_ready,
    output logic                      out_valid,
    output frdr_pkg::out_item_t       out_data,
    input  frdr_pkg::ctl_cmd_t        cmd,
    output frdr_pkg::ctl_status_t     status
);
    import frdr_pkg::*;

    localparam logic [REP_W-1:0] REP_CAP = REP_W'(MAX_REPEATS);
    localparam logic [REP_W-1:0] REP_CAP_M1 = REP_W'(MAX_REPEATS - 1);

    logic [CFG_W-1:0] period_reg, period_next;
    logic [CFG_W-1:0] limit_reg, limit_next;
    logic [PTS_W-1:0] ts_reg, ts_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [PTS_W-1:0] prev_reg, prev_next;
    logic [PTS_W-1:0] exp_reg, exp_next;
    logic [PTS_W-1:0] exp2_reg, exp2_next;
    logic             have_prev_reg, have_prev_next;
    logic [TAG_W-1:0] held_tag_reg, held_tag_next;
    logic             held_unused_reg, held_unused_next;
    logic [CNT_W-1:0] dup_reg, dup_next;
    logic [CNT_W-1:0] drop_reg, drop_next;
    logic [CNT_W-1:0] fin_reg, fin_next;
    logic [CNT_W-1:0] fout_reg, fout_next;
    logic [REP_W-1:0] n_reg, n_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic [PTS_W:0]   gap;
    logic             jump;
    logic             aligned;
    logic             look_more;
    logic             look_early;
    logic [PTS_W-1:0] period_ext;

    assign period_ext = {{(PTS_W-CFG_W){1'b0}}, period_reg};
    assign gap = {ts_reg[PTS_W-1], ts_reg} - {prev_reg[PTS_W-1], prev_reg};
    assign jump = gap[PTS_W] || (gap[PTS_W-1:0] > {{(PTS_W-CFG_W){1'b0}}, limit_reg});
    assign aligned = !gap[PTS_W] && (gap[PTS_W-1:0] == period_ext);
    assign look_more = ($signed(ts_reg) > $signed(exp2_reg)) && (n_reg < REP_CAP_M1);
    assign look_early = $signed(ts_reg) < $signed(exp2_reg);

    assign status.item_valid  = in_data.in_valid;
    assign status.pass_direct = !have_prev_reg || aligned || jump;
    assign status.rep_more    = ($signed(ts_reg) > $signed(exp_reg)) && (n_reg < REP_CAP);
    assign status.early       = $signed(ts_reg) < $signed(exp_reg);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        period_next      = period_reg;
        limit_next       = limit_reg;
        ts_next          = ts_reg;
        tag_next         = tag_reg;
        prev_next        = prev_reg;
        exp_next         = exp_reg;
        exp2_next        = exp2_reg;
        have_prev_next   = have_prev_reg;
        held_tag_next    = held_tag_reg;
        held_unused_next = held_unused_reg;
        dup_next         = dup_reg;
        drop_next        = drop_reg;
        fin_next         = fin_reg;
        fout_next        = fout_reg;
        n_next           = n_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_idx))
                CFG_FRAME_PERIOD: period_next = cfg_data;
                CFG_JUMP_LIMIT:   limit_next = cfg_data;
                default:          period_next = period_reg;
            endcase
        end

        if (cmd.load)
        begin
            ts_next  = in_data.in_pts;
            tag_next = in_data.in_tag;
        end

        if (cmd.eval)
        begin
            exp2_next = exp_reg + period_ext;
            n_next    = '0;
        end

        if (cmd.rep_emit)
        begin
            dup_next         = dup_reg + {{(CNT_W-1){1'b0}}, !held_unused_reg};
            fout_next        = fout_reg + CNT_W'(1);
            held_unused_next = 1'b0;
            exp_next         = exp2_reg;
            exp2_next        = exp2_reg + period_ext;
            n_next           = n_reg + REP_W'(1);
            out_valid_next   = 1'b1;
            out_data_next.out_pts    = exp_reg;
            out_data_next.out_tag    = held_tag_reg;
            out_data_next.repeated   = 1'b1;
            // last repeat of the run only when the frame then turns out early
            out_data_next.run_end    = !look_more && look_early;
            out_data_next.dup_count  = dup_next;
            out_data_next.drop_count = drop_reg;
            out_data_next.frames_in  = fin_reg;
            out_data_next.frames_out = fout_next;
        end

        if (cmd.early)
        begin
            drop_next        = drop_reg + {{(CNT_W-1){1'b0}}, held_unused_reg};
            held_tag_next    = tag_reg;
            held_unused_next = 1'b1;
            fin_next         = fin_reg + CNT_W'(1);
        end

        if (cmd.pass_emit)
        begin
            drop_next        = drop_reg + {{(CNT_W-1){1'b0}}, held_unused_reg};
            fin_next         = fin_reg + CNT_W'(1);
            fout_next        = fout_reg + CNT_W'(1);
            prev_next        = ts_reg;
            exp_next         = ts_reg + period_ext;
            have_prev_next   = 1'b1;
            held_tag_next    = tag_reg;
            held_unused_next = 1'b0;
            out_valid_next   = 1'b1;
            out_data_next.out_pts    = ts_reg;
            out_data_next.out_tag    = tag_reg;
            out_data_next.repeated   = 1'b0;
            out_data_next.run_end    = 1'b1;
            out_data_next.dup_count  = dup_reg;
            out_data_next.drop_count = drop_next;
            out_data_next.frames_in  = fin_next;
            out_data_next.frames_out = fout_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg      <= PERIOD_RESET;
            limit_reg       <= LIMIT_RESET;
            prev_reg        <= '0;
            exp_reg         <= '0;
            have_prev_reg   <= 1'b0;
            held_tag_reg    <= '0;
            held_unused_reg <= 1'b0;
            dup_reg         <= '0;
            drop_reg        <= '0;
            fin_reg         <= '0;
            fout_reg        <= '0;
            n_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            period_reg      <= period_next;
            limit_reg       <= limit_next;
            prev_reg        <= prev_next;
            exp_reg         <= exp_next;
            have_prev_reg   <= have_prev_next;
            held_tag_reg    <= held_tag_next;
            held_unused_reg <= held_unused_next;
            dup_reg         <= dup_next;
            drop_reg        <= drop_next;
            fin_reg         <= fin_next;
            fout_reg        <= fout_next;
            n_reg           <= n_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg       <= ts_next;
        tag_reg      <= tag_next;
        exp2_reg     <= exp2_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hdl/frame_rate_drop_repeat_core.sv =====
// Top level: constant frame rate by dropping and repeating frame descriptors.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+------------------------------------------
//  in_ch    | in  | valid / ready   | in_pts, in_tag, in_valid
//  out_ch   | out | valid / ready   | out_pts, out_tag, repeated, run_end,
//           |     |                 | dup_count, drop_count, frames_in, frames_out
//  cfg      | in  | cfg_we          | cfg_idx (0 frame_period, 1 jump_limit), cfg_data
//
// An item with in_valid low is taken and leaves no trace.
// A directly passing frame goes through accept, gap check (49-bit subtract
// and compare) and emit. Any other frame goes through the repeat loop: one
// repeat per due slot, up to 63, then a step that sees the loop end; an early
// frame leaves from there with no result, otherwise the emit step follows.
// Results sit in a single output register; a stall there holds the loop.
// Reset is asynchronous; no clearing pass, the block is ready right away.
`timescale 1ns / 1ps
module frame_rate_drop_repeat_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_idx,
    input  logic [frdr_pkg::CFG_W-1:0] cfg_data,
    frdr_in_if.sink                    in_ch,
    frdr_out_if.source                 out_ch
);
    import frdr_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    // ready is high only while the controller waits for a new item
    assign in_ch.ready = cmd.ready;

    frdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .status   (status),
        .cmd      (cmd)
    );

    // timestamps, running totals and the output register live here
    frdr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_data   (in_ch.data),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_data  (out_ch.data),
        .cmd       (cmd),
        .status    (status)
    );

    // a result is only written into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rep_emit || cmd.pass_emit) |-> status.out_free)
        else $error("result written into occupied output register");

    // no new item is taken while a frame is still being worked on
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval || cmd.rep_emit || cmd.early || cmd.pass_emit) |-> !in_ch.ready)
        else $error("input ready while a frame is in progress");

    // controller steps are mutually exclusive
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.eval, cmd.rep_emit, cmd.early, cmd.pass_emit}))
        else $error("more than one controller step at once");

    // an emit always shows up at the output in the next cycle
    a_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rep_emit || cmd.pass_emit) |=> out_ch.valid)
        else $error("emitted result not presented");

endmodule
